// ===== design/drs_pkg.sv =====
`default_nettype none

package drs_pkg;

  // Default batch size
  localparam int unsigned COUNT_DEF = 8;

  // Fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PLACE_W = 3;

endpackage

`default_nettype wire

// ===== design/drs_ram.sv =====
`default_nettype none

// Generic single-write, single-read RAM with registered read data
module drs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/descending_rank_sort_core.sv =====
`default_nettype none

// Channel  | Handshake                   | Payload
// -------- | --------------------------- | ----------------------------------------
// sample   | sample_valid / sample_ready | sample_value (s32)
// result   | result_valid / result_ready | place (u3), ranked_value (s32), final_place
//
// Loading accepts a value whenever sample_valid is high; a batch holds COUNT values.
// Ranking then handles each value in turn: it fetches the value, sweeps the held-value RAM
// through one shared signed comparator, drains the last compare and writes the value to its place.
// After place 0 is fetched, results leave one per cycle while result_ready is high.
// sample_ready is low from the last value of a batch until its final result is taken.
// Reset (rst, synchronous) empties the batch and drops result_valid.
module descending_rank_sort_core #(
  parameter int unsigned COUNT = drs_pkg::COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sample_valid,
  output logic                                     sample_ready,
  input  wire logic signed [drs_pkg::VALUE_W-1:0]  sample_value,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic             [drs_pkg::PLACE_W-1:0]  place,
  output logic signed      [drs_pkg::VALUE_W-1:0]  ranked_value,
  output logic                                     final_place
);

  localparam int unsigned IW = $clog2(COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(COUNT - 1);
  localparam logic [drs_pkg::PLACE_W-1:0] LAST_PLACE = drs_pkg::PLACE_W'(COUNT - 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LATCH_I,
    ST_SWEEP,
    ST_DRAIN,
    ST_WRITE,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_t;

  state_t state;

  logic [IW-1:0]                      load_cnt;
  logic [IW-1:0]                      i_idx;
  logic [IW-1:0]                      j_idx;
  logic [IW-1:0]                      pend_j;
  logic                               pend;
  logic [IW-1:0]                      pos;
  logic [IW-1:0]                      k_idx;
  logic signed [drs_pkg::VALUE_W-1:0] vi;

  logic                        held_rd_en;
  logic [IW-1:0]               held_rd_addr;
  logic [drs_pkg::VALUE_W-1:0] held_rd_data;
  logic                        sort_rd_en;
  logic [IW-1:0]               sort_rd_addr;
  logic [drs_pkg::VALUE_W-1:0] sort_rd_data;
  logic                        load_acc;
  logic                        out_acc;
  logic                        hit;

  assign sample_ready = (state == ST_LOAD);
  assign load_acc     = sample_valid && sample_ready;
  assign out_acc      = result_valid && result_ready;
  assign ranked_value = $signed(sort_rd_data);

  // Shared comparator: count entries above vi, and equal entries that arrived earlier
  always_comb begin
    hit = pend && (($signed(held_rd_data) > vi) ||
                   ((pend_j < i_idx) && ($signed(held_rd_data) == vi)));
  end

  // Read port steering for both stores
  always_comb begin
    held_rd_en   = 1'b0;
    held_rd_addr = j_idx;
    sort_rd_en   = 1'b0;
    sort_rd_addr = k_idx;
    unique case (state)
      ST_RD_I: begin
        held_rd_en   = 1'b1;
        held_rd_addr = i_idx;
      end
      ST_SWEEP: begin
        held_rd_en = 1'b1;
      end
      ST_OUT_RD: begin
        sort_rd_en = 1'b1;
      end
      ST_OUT_SHOW: begin
        sort_rd_en   = out_acc && !final_place;
        sort_rd_addr = k_idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  drs_ram #(
    .WIDTH (drs_pkg::VALUE_W),
    .DEPTH (COUNT)
  ) u_held (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr (load_cnt),
    .wr_data (sample_value),
    .rd_en   (held_rd_en),
    .rd_addr (held_rd_addr),
    .rd_data (held_rd_data)
  );

  drs_ram #(
    .WIDTH (drs_pkg::VALUE_W),
    .DEPTH (COUNT)
  ) u_sorted (
    .clk     (clk),
    .wr_en   (state == ST_WRITE),
    .wr_addr (pos),
    .wr_data (vi),
    .rd_en   (sort_rd_en),
    .rd_addr (sort_rd_addr),
    .rd_data (sort_rd_data)
  );

  // Sequencer: load, rank each value by a full sweep, then stream out by place
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      load_cnt     <= '0;
      i_idx        <= '0;
      j_idx        <= '0;
      pend         <= 1'b0;
      pos          <= '0;
      k_idx        <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (load_acc) begin
            if (load_cnt == LAST_IDX) begin
              load_cnt <= '0;
              i_idx    <= '0;
              state    <= ST_RD_I;
            end else begin
              load_cnt <= load_cnt + 1'b1;
            end
          end
        end
        ST_RD_I: begin
          state <= ST_LATCH_I;
        end
        ST_LATCH_I: begin
          vi    <= $signed(held_rd_data);
          j_idx <= '0;
          pos   <= '0;
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          pend   <= 1'b1;
          pend_j <= j_idx;
          if (hit) begin
            pos <= pos + 1'b1;
          end
          if (j_idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            j_idx <= j_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          pend <= 1'b0;
          if (hit) begin
            pos <= pos + 1'b1;
          end
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (i_idx == LAST_IDX) begin
            k_idx <= '0;
            state <= ST_OUT_RD;
          end else begin
            i_idx <= i_idx + 1'b1;
            state <= ST_RD_I;
          end
        end
        ST_OUT_RD: begin
          result_valid <= 1'b1;
          place        <= '0;
          final_place  <= 1'b0;
          state        <= ST_OUT_SHOW;
        end
        ST_OUT_SHOW: begin
          if (out_acc) begin
            if (final_place) begin
              result_valid <= 1'b0;
              state        <= ST_LOAD;
            end else begin
              k_idx       <= k_idx + 1'b1;
              place       <= drs_pkg::PLACE_W'(k_idx + 1'b1);
              final_place <= ((k_idx + 1'b1) == LAST_IDX);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Never take a value while a result is on offer
  assert property (@(posedge clk) disable iff (rst) !(sample_ready && result_valid))
    else $error("sample_ready and result_valid high together");

  // The final result carries the last place
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && final_place) |-> (place == LAST_PLACE))
    else $error("final_place on wrong place");

  // Taking the final result reopens the input
  assert property (@(posedge clk) disable iff (rst)
    (out_acc && final_place) |=> (sample_ready && !result_valid))
    else $error("input not reopened after batch");

  // A sweep always leaves a compare in flight for the drain cycle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |=> pend)
    else $error("compare pipeline lost an entry");
`endif

endmodule

`default_nettype wire
